@@ hdl/vrt_pkg.sv @@
`default_nettype none
package vrt_pkg;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int COORD_BITS_DEF = 32;
	localparam int ORG_W  = 48;
	localparam int DIR_W  = 16;
	localparam int DIST_W = 48;
	localparam int MAXD_W = 32;
	localparam int OUT_W  = 32;
	localparam int NUM_JOBS = 6;
	localparam logic [DIST_W-1:0] DIST_SAT  = '1;
	localparam logic [MAXD_W-1:0] MAXD_RST  = 32'd524288;

	typedef enum logic [1:0] {
		KIND_QUERY = 2'd0,
		KIND_HIT   = 2'd1,
		KIND_MISS  = 2'd2,
		KIND_IDLE  = 2'd3
	} kind_t;

	typedef enum logic [0:0] {
		REQ_START  = 1'b0,
		REQ_ANSWER = 1'b1
	} req_t;

	typedef struct packed {
		logic       load_start;
		logic       div_start;
		logic       div_wr;
		logic       sel_axis;
		logic       advance;
		logic       load_out;
		kind_t      out_kind;
		logic [2:0] job;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic beyond;
		logic out_free;
	} stat_t;
endpackage
`default_nettype wire

@@ hdl/vrt_ifs.sv @@
`default_nettype none
interface vrt_req_if;
	import vrt_pkg::*;
	logic                    valid;
	logic                    ready;
	logic                    req_type;
	logic signed [ORG_W-1:0] origin_x;
	logic signed [ORG_W-1:0] origin_y;
	logic signed [ORG_W-1:0] origin_z;
	logic signed [DIR_W-1:0] dir_x;
	logic signed [DIR_W-1:0] dir_y;
	logic signed [DIR_W-1:0] dir_z;
	logic                    occupied;
	modport source (output valid, req_type, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		occupied, input ready);
	modport sink (input valid, req_type, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		occupied, output ready);
endinterface

interface vrt_rsp_if;
	import vrt_pkg::*;
	logic                    valid;
	logic                    ready;
	kind_t                   kind;
	logic signed [OUT_W-1:0] cell_x;
	logic signed [OUT_W-1:0] cell_y;
	logic signed [OUT_W-1:0] cell_z;
	logic signed [OUT_W-1:0] prev_x;
	logic signed [OUT_W-1:0] prev_y;
	logic signed [OUT_W-1:0] prev_z;
	modport source (output valid, kind, cell_x, cell_y, cell_z, prev_x, prev_y, prev_z,
		input ready);
	modport sink (input valid, kind, cell_x, cell_y, cell_z, prev_x, prev_y, prev_z,
		output ready);
endinterface
`default_nettype wire

@@ hdl/vrt_div.sv @@
`default_nettype none
// restoring divider, one quotient bit per cycle
module vrt_div #(
	parameter int NW = 32,
	parameter int DW = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic [NW-1:0]      quo
);
	localparam int CW = $clog2(NW + 1);

	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [DW:0]   trial;
	logic          ge;

	assign trial = {rem_q, quo_q[NW-1]};
	assign ge    = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

@@ hdl/vrt_dp.sv @@
`default_nettype none
module vrt_dp
	import vrt_pkg::*;
#(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [MAXD_W-1:0]       cfg_wdata,
	input  wire cmd_t                    cmd,
	output stat_t                        stat,
	input  wire logic signed [ORG_W-1:0] origin_x,
	input  wire logic signed [ORG_W-1:0] origin_y,
	input  wire logic signed [ORG_W-1:0] origin_z,
	input  wire logic signed [DIR_W-1:0] dir_x,
	input  wire logic signed [DIR_W-1:0] dir_y,
	input  wire logic signed [DIR_W-1:0] dir_z,
	vrt_rsp_if.source                    rsp
);
	localparam int NW = FRAC_BITS + 16;

	logic [MAXD_W-1:0]     maxd_q;
	logic [COORD_BITS-1:0] cur_q [3];
	logic [COORD_BITS-1:0] prv_q [3];
	logic [DIST_W-1:0]     nb_q [3];
	logic [DIST_W-1:0]     dl_q [3];
	logic [FRAC_BITS-1:0]  frac_q [3];
	logic [DIR_W-1:0]      mag_q [3];
	logic [2:0]            neg_q, zero_q;
	logic [1:0]            ax_q;
	logic                  out_valid_q;
	kind_t                 kind_q;
	logic [OUT_W-1:0]      oc_q [3];
	logic [OUT_W-1:0]      op_q [3];

	logic signed [ORG_W-1:0] org [3];
	logic signed [DIR_W-1:0] dir [3];
	logic [1:0]              ja, ax_c;
	logic [NW-1:0]           num;
	logic [NW-1:0]           quo;
	logic                    div_done;
	logic [DIST_W:0]         nsum;

	assign org[0] = origin_x;
	assign org[1] = origin_y;
	assign org[2] = origin_z;
	assign dir[0] = dir_x;
	assign dir[1] = dir_y;
	assign dir[2] = dir_z;

	// job: axis in upper bits, bit 0 selects delta (0) or first boundary (1)
	assign ja = cmd.job[2:1];
	always_comb begin
		if (!cmd.job[0])
			num = NW'(1) << (15 + FRAC_BITS);
		else if (neg_q[ja])
			num = NW'(frac_q[ja]) << 15;
		else
			num = NW'((FRAC_BITS+1)'(1) << FRAC_BITS) - NW'(frac_q[ja]) << 15;
	end

	vrt_div #(.NW(NW), .DW(DIR_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num),
		.den    (mag_q[ja]),
		.done   (div_done),
		.quo    (quo)
	);

	always_comb begin
		ax_c = (nb_q[1] < nb_q[0]) ? 2'd1 : 2'd0;
		if (nb_q[2] < nb_q[ax_c])
			ax_c = 2'd2;
	end

	assign nsum = {1'b0, nb_q[ax_q]} + {1'b0, dl_q[ax_q]};

	assign stat.div_done = div_done;
	assign stat.beyond   = nb_q[ax_q] > DIST_W'(maxd_q);
	assign stat.out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maxd_q      <= MAXD_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				maxd_q <= cfg_wdata;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [63:0] ce;
		if (cmd.load_start) begin
			for (int a = 0; a < 3; a++) begin
				ce        = 64'(signed'(org[a][ORG_W-1:FRAC_BITS]));
				cur_q[a]  <= ce[COORD_BITS-1:0];
				prv_q[a]  <= ce[COORD_BITS-1:0];
				frac_q[a] <= org[a][FRAC_BITS-1:0];
				neg_q[a]  <= dir[a][DIR_W-1];
				zero_q[a] <= dir[a] == '0;
				mag_q[a]  <= dir[a][DIR_W-1] ? DIR_W'(-dir[a]) : dir[a];
			end
		end
		if (cmd.div_wr) begin
			if (cmd.job[0])
				nb_q[ja] <= zero_q[ja] ? DIST_SAT : DIST_W'(quo);
			else
				dl_q[ja] <= zero_q[ja] ? DIST_SAT : DIST_W'(quo);
		end
		if (cmd.sel_axis)
			ax_q <= ax_c;
		if (cmd.advance) begin
			for (int a = 0; a < 3; a++)
				prv_q[a] <= cur_q[a];
			if (!zero_q[ax_q])
				cur_q[ax_q] <= neg_q[ax_q] ? cur_q[ax_q] - 1'b1 : cur_q[ax_q] + 1'b1;
			nb_q[ax_q] <= nsum[DIST_W] ? DIST_SAT : nsum[DIST_W-1:0];
		end
		if (cmd.load_out) begin
			kind_q <= cmd.out_kind;
			for (int a = 0; a < 3; a++) begin
				if (cmd.out_kind == KIND_QUERY || cmd.out_kind == KIND_HIT) begin
					ce       = 64'(signed'(cur_q[a]));
					oc_q[a]  <= ce[OUT_W-1:0];
					ce       = 64'(signed'(prv_q[a]));
					op_q[a]  <= ce[OUT_W-1:0];
				end else begin
					oc_q[a] <= '0;
					op_q[a] <= '0;
				end
			end
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.kind   = kind_q;
	assign rsp.cell_x = oc_q[0];
	assign rsp.cell_y = oc_q[1];
	assign rsp.cell_z = oc_q[2];
	assign rsp.prev_x = op_q[0];
	assign rsp.prev_y = op_q[1];
	assign rsp.prev_z = op_q[2];
endmodule
`default_nettype wire

@@ hdl/vrt_ctrl.sv @@
`default_nettype none
module vrt_ctrl
	import vrt_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  req_valid,
	input  wire logic  req_type,
	input  wire logic  occupied,
	output logic       req_ready,
	output cmd_t       cmd,
	input  wire stat_t stat
);
	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_DIV_GO   = 6'b000010,
		ST_DIV_WAIT = 6'b000100,
		ST_SEL      = 6'b001000,
		ST_ADV      = 6'b010000,
		ST_EMIT     = 6'b100000
	} state_t;

	state_t     state_q, state_d;
	logic [2:0] job_q, job_d;
	logic       active_q, active_d;
	kind_t      kind_q, kind_d;

	assign req_ready = state_q == ST_IDLE;

	always_comb begin
		state_d  = state_q;
		job_d    = job_q;
		active_d = active_q;
		kind_d   = kind_q;
		cmd      = '0;
		cmd.job      = job_q;
		cmd.out_kind = kind_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (req_type == REQ_START) begin
						cmd.load_start = 1'b1;
						job_d   = '0;
						state_d = ST_DIV_GO;
					end else if (!active_q) begin
						kind_d  = KIND_IDLE;
						state_d = ST_EMIT;
					end else if (occupied) begin
						active_d = 1'b0;
						kind_d   = KIND_HIT;
						state_d  = ST_EMIT;
					end else begin
						state_d = ST_SEL;
					end
				end
			end
			ST_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_d = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (stat.div_done) begin
					cmd.div_wr = 1'b1;
					if (job_q == 3'(NUM_JOBS - 1)) begin
						active_d = 1'b1;
						state_d  = ST_SEL;
					end else begin
						job_d   = job_q + 1'b1;
						state_d = ST_DIV_GO;
					end
				end
			end
			ST_SEL: begin
				cmd.sel_axis = 1'b1;
				state_d = ST_ADV;
			end
			ST_ADV: begin
				if (stat.beyond) begin
					active_d = 1'b0;
					kind_d   = KIND_MISS;
				end else begin
					cmd.advance = 1'b1;
					kind_d      = KIND_QUERY;
				end
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			job_q    <= '0;
			active_q <= 1'b0;
			kind_q   <= KIND_IDLE;
		end else begin
			state_q  <= state_d;
			job_q    <= job_d;
			active_q <= active_d;
			kind_q   <= kind_d;
		end
	end
endmodule
`default_nettype wire

@@ hdl/voxel_ray_traversal.sv @@
`default_nettype none
// 3D DDA voxel walker. A start word sets up the ray with six serial divisions on one shared
// restoring divider before its first query. An answer word that continues the walk goes
// through decode, axis select, advance and output load; a hit or idle answer skips to
// output load. The walk itself is paced by the external occupancy round trip. The result
// register lets a new word be accepted while the last result is still waiting to be taken.
module voxel_ray_traversal
	import vrt_pkg::*;
#(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [MAXD_W-1:0] cfg_wdata,
	vrt_req_if.sink                req,
	vrt_rsp_if.source              rsp
);
	cmd_t  cmd;
	stat_t stat;

	vrt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.occupied  (req.occupied),
		.req_ready (req.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	vrt_dp #(.FRAC_BITS(FRAC_BITS), .COORD_BITS(COORD_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.origin_x  (req.origin_x),
		.origin_y  (req.origin_y),
		.origin_z  (req.origin_z),
		.dir_x     (req.dir_x),
		.dir_y     (req.dir_y),
		.dir_z     (req.dir_z),
		.rsp       (rsp)
	);

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> stat.out_free) else $error("result loaded over a pending word");
	a_wr_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_wr |-> stat.div_done) else $error("quotient written before divide done");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.kind == KIND_MISS || rsp.kind == KIND_IDLE) |->
		rsp.cell_x == '0 && rsp.prev_z == '0) else $error("nonzero coords on miss");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !req.ready) else $error("input taken during setup");
endmodule
`default_nettype wire
